FILE: hdl/tsa_pkg.sv
package tsa_pkg;

	// Warm-up register.
	localparam int unsigned WARMUP_W = 4;
	localparam logic [WARMUP_W-1:0] WARMUP_RESET = 4'd2;

	// Position counter within a run; it stops at its all-ones value.
	localparam int unsigned COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// Status of a run that has just closed, handed to the output stage.
	typedef struct packed {
		logic too_few;
		logic saturated;
	} run_flags_t;

endpackage

FILE: hdl/tsa_sorted_list.sv
module tsa_sorted_list #(
	parameter int unsigned DEPTH      = 3,
	parameter int unsigned WIDTH      = 32,
	parameter bit          KEEP_LARGE = 1'b1
) (
	input  logic                             clk,
	input  logic                             ins_en,
	input  logic [WIDTH-1:0]                 ins_value,
	input  logic [$clog2(DEPTH+1)-1:0]       used,
	output logic [DEPTH-1:0][WIDTH-1:0]      entries_next
);

	localparam int unsigned USED_W = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][WIDTH-1:0] entries_q;
	logic [DEPTH-1:0]            goes_before;

	// The list is sorted, so goes_before is false over a prefix and true after it.
	// The new value lands at the first true position and the tail moves down one.
	// With ins_en high, positions at or beyond the valid count always take the new value or a shifted one.
	// With ins_en low the held entries are shown unchanged.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			goes_before[i] = (USED_W'(i) >= used) ||
				(KEEP_LARGE ? (ins_value > entries_q[i]) : (ins_value < entries_q[i]));
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (!ins_en || !goes_before[i]) begin
				entries_next[i] = entries_q[i];
			end else if (i == 0) begin
				entries_next[i] = ins_value;
			end else if (!goes_before[i-1]) begin
				entries_next[i] = ins_value;
			end else begin
				entries_next[i] = entries_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			entries_q <= entries_next;
		end
	end

endmodule

FILE: hdl/tsa_trim_out.sv
module tsa_trim_out #(
	parameter int unsigned TRIM_EACH_SIDE = 3,
	parameter int unsigned SAMPLE_BITS    = 32,
	parameter int unsigned SUM_BITS       = 48
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        load,
	input  logic [SUM_BITS-1:0]                         sum_in,
	input  tsa_pkg::run_flags_t                         flags_in,
	input  logic [TRIM_EACH_SIDE-1:0][SAMPLE_BITS-1:0]  large_in,
	input  logic [TRIM_EACH_SIDE-1:0][SAMPLE_BITS-1:0]  small_in,
	output logic                                        ready,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic [SUM_BITS-1:0]                         trimmed_sum,
	output logic                                        too_few
);

	logic                                        valid_s2;
	logic [SUM_BITS-1:0]                         sum_s2;
	tsa_pkg::run_flags_t                         flags_s2;
	logic [TRIM_EACH_SIDE-1:0][SAMPLE_BITS-1:0]  large_s2;
	logic [TRIM_EACH_SIDE-1:0][SAMPLE_BITS-1:0]  small_s2;

	logic                out_valid_q;
	logic [SUM_BITS-1:0] trimmed_sum_q;
	logic                too_few_q;

	logic                out_load;
	logic [SUM_BITS-1:0] removed;
	logic [SUM_BITS-1:0] result;

	assign out_load = valid_s2 && (!out_valid_q || !out_stall);
	assign ready    = !valid_s2 || out_load;

	// The removed samples never exceed the sum, so arithmetic modulo the sum width is exact.
	always_comb begin
		removed = '0;
		for (int i = 0; i < TRIM_EACH_SIDE; i++) begin
			removed = removed + SUM_BITS'(large_s2[i]) + SUM_BITS'(small_s2[i]);
		end
		if (flags_s2.too_few) begin
			result = '0;
		end else if (flags_s2.saturated) begin
			result = '1;
		end else begin
			result = sum_s2 - removed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (out_load) begin
				valid_s2 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_s2   <= sum_in;
			flags_s2 <= flags_in;
			large_s2 <= large_in;
			small_s2 <= small_in;
		end
		if (out_load) begin
			trimmed_sum_q <= result;
			too_few_q     <= flags_s2.too_few;
		end
	end

	assign out_valid   = out_valid_q;
	assign trimmed_sum = trimmed_sum_q;
	assign too_few     = too_few_q;

endmodule

FILE: hdl/trimmed_sum_accumulator.sv
// Trimmed sum of a run of timing samples.
// Input channel: sample and last, qualified by in_valid, held off by in_stall. An item
// is taken at a rising edge with in_valid high and in_stall low. Output channel:
// trimmed_sum and too_few, qualified by out_valid, held off by out_stall.
// The first warmup_count items of a run are dropped; the rest are summed (the sum
// saturates at all ones) and offered to two sorted lists holding the three largest and
// three smallest kept samples. The item with last high closes the run and produces one
// result: the sum less those six samples, or zero with too_few high if fewer than six
// samples were kept, or all ones once the sum has saturated. Run state then clears.
// Timing: an item is held in the input register, where it updates the run state; a
// closing item then moves through the trim stage and the output register before its
// result is offered. One item is taken every cycle while in_stall is low; the
// run-state update is a single compare-insert and add per cycle.
// When out_stall is held, up to two results wait in the trim stage and the output
// register, and ordinary items keep flowing; a closing item waits in the input register
// and in_stall rises only when both of those are full.
// warmup_count is written through warmup_count_we and warmup_count_wdata; the user must
// write it only while the block is idle, and the block itself does not enforce this.
// Reset clears all run state and sets warmup_count to two.
module trimmed_sum_accumulator #(
	parameter int unsigned TRIM_EACH_SIDE = 3,
	parameter int unsigned SAMPLE_BITS    = 32,
	parameter int unsigned SUM_BITS       = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           warmup_count_we,
	input  logic [tsa_pkg::WARMUP_W-1:0]   warmup_count_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [SAMPLE_BITS-1:0]         sample,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [SUM_BITS-1:0]            trimmed_sum,
	output logic                           too_few
);

	localparam int unsigned FILL_W = $clog2(2 * TRIM_EACH_SIDE + 1);
	localparam int unsigned USED_W = $clog2(TRIM_EACH_SIDE + 1);
	localparam int unsigned ACC_W  = ((SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS) + 1;
	localparam logic [FILL_W-1:0] KEEP_NEEDED = FILL_W'(2 * TRIM_EACH_SIDE);
	localparam logic [FILL_W-1:0] TRIM_FILL   = FILL_W'(TRIM_EACH_SIDE);

	// Configuration.
	logic [tsa_pkg::WARMUP_W-1:0] warmup_q;

	// Input register.
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   last_s1;

	// Run state.
	logic [tsa_pkg::COUNT_W-1:0] count_q;
	logic [FILL_W-1:0]           fill_q;
	logic [SUM_BITS-1:0]         sum_q;
	logic                        sat_q;

	logic                        s1_go;
	logic                        fire;
	logic                        accept;
	logic                        keep;
	logic                        out_ready;
	logic [USED_W-1:0]           used;
	logic [ACC_W-1:0]            sum_wide;
	logic                        sat_next;
	logic [SUM_BITS-1:0]         sum_next;
	logic [FILL_W-1:0]           fill_next;
	logic [tsa_pkg::COUNT_W-1:0] count_next;
	tsa_pkg::run_flags_t         end_flags;

	logic [TRIM_EACH_SIDE-1:0][SAMPLE_BITS-1:0] large_next;
	logic [TRIM_EACH_SIDE-1:0][SAMPLE_BITS-1:0] small_next;

	// A closing item may only leave the input register when the trim stage can take it.
	assign s1_go    = !last_s1 || out_ready;
	assign fire     = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;
	assign accept   = in_valid && !in_stall;

	// A sample is kept once its position in the run reaches the warm-up count.
	assign keep = count_q >= tsa_pkg::COUNT_W'(warmup_q);
	assign used = (fill_q < TRIM_FILL) ? USED_W'(fill_q) : USED_W'(TRIM_EACH_SIDE);

	// Saturating add; the extra top bits catch both carry out and a sample wider than the sum.
	always_comb begin
		sum_wide = ACC_W'(sum_q) + ACC_W'(sample_s1);
		if (keep) begin
			sat_next  = sat_q || (|sum_wide[ACC_W-1:SUM_BITS]);
			sum_next  = sat_next ? '1 : sum_wide[SUM_BITS-1:0];
			fill_next = (fill_q < KEEP_NEEDED) ? fill_q + FILL_W'(1) : fill_q;
		end else begin
			sat_next  = sat_q;
			sum_next  = sum_q;
			fill_next = fill_q;
		end
		count_next = (count_q != tsa_pkg::COUNT_MAX) ? count_q + tsa_pkg::COUNT_W'(1) : count_q;
		end_flags.too_few   = fill_next != KEEP_NEEDED;
		end_flags.saturated = sat_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= tsa_pkg::WARMUP_RESET;
			valid_s1 <= 1'b0;
			count_q  <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			sat_q    <= 1'b0;
		end else begin
			if (warmup_count_we) begin
				warmup_q <= warmup_count_wdata;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				if (last_s1) begin
					count_q <= '0;
					fill_q  <= '0;
					sum_q   <= '0;
					sat_q   <= 1'b0;
				end else begin
					count_q <= count_next;
					fill_q  <= fill_next;
					sum_q   <= sum_next;
					sat_q   <= sat_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			last_s1   <= last;
		end
	end

	// List entries past the fill count are never read, so the lists need no clearing.
	tsa_sorted_list #(
		.DEPTH      (TRIM_EACH_SIDE),
		.WIDTH      (SAMPLE_BITS),
		.KEEP_LARGE (1'b1)
	) u_largest (
		.clk          (clk),
		.ins_en       (fire && keep),
		.ins_value    (sample_s1),
		.used         (used),
		.entries_next (large_next)
	);

	tsa_sorted_list #(
		.DEPTH      (TRIM_EACH_SIDE),
		.WIDTH      (SAMPLE_BITS),
		.KEEP_LARGE (1'b0)
	) u_smallest (
		.clk          (clk),
		.ins_en       (fire && keep),
		.ins_value    (sample_s1),
		.used         (used),
		.entries_next (small_next)
	);

	tsa_trim_out #(
		.TRIM_EACH_SIDE (TRIM_EACH_SIDE),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.SUM_BITS       (SUM_BITS)
	) u_trim_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (fire && last_s1),
		.sum_in      (sum_next),
		.flags_in    (end_flags),
		.large_in    (large_next),
		.small_in    (small_next),
		.ready       (out_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.trimmed_sum (trimmed_sum),
		.too_few     (too_few)
	);

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

	// Block configuration under test. These match the defaults of the block.
	localparam int unsigned TRIM_EACH_SIDE = 3;
	localparam int unsigned SAMPLE_BITS    = 32;
	localparam int unsigned SUM_BITS       = 48;
	localparam int unsigned KEEP_NEEDED    = 2 * TRIM_EACH_SIDE;
	localparam logic [SUM_BITS-1:0] SUM_ALL_ONES = {SUM_BITS{1'b1}};

	// A closing item passes through the input register, the trim stage and the output
	// register, so SETTLE_CYCLES of quiet after the last result lets the block settle.
	localparam int SETTLE_CYCLES   = 5;
	// Longest stretch in which neither channel moves before the run is declared hung.
	localparam int WATCHDOG_LIMIT  = 1000;
	// Random part: phases of items, each phase opening with a warm-up write.
	localparam int RAND_PHASES     = 8;
	localparam int PHASE_ITEMS     = 135;
	// One long run of mostly all-ones samples that drives the sum far up its range.
	localparam int LONG_RUN_ITEMS  = 100;
	localparam int MAX_PRINTED     = 40;

	typedef logic [TRIM_EACH_SIDE-1:0][SAMPLE_BITS-1:0] trio_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] total;
		logic                short_run;
	} trim_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_WARMUP} row_kind_t;

	// One line of the directed table: either an item or a warm-up write. Rows with
	// known_answer set carry the result that their closing item must produce.
	typedef struct packed {
		row_kind_t              kind;
		logic [SAMPLE_BITS-1:0] value;
		logic                   closes;
		logic                   known_answer;
		logic [SUM_BITS-1:0]    want_total;
		logic                   want_short;
	} row_t;

	// Every input of the block starts at a known value.
	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         warmup_count_we = 1'b0;
	logic [tsa_pkg::WARMUP_W-1:0] warmup_count_wdata = '0;
	logic                         in_valid = 1'b0;
	logic [SAMPLE_BITS-1:0]       sample = '0;
	logic                         last = 1'b0;
	logic                         out_stall = 1'b0;
	wire                          in_stall;
	wire                          out_valid;
	wire [SUM_BITS-1:0]           trimmed_sum;
	wire                          too_few;

	trimmed_sum_accumulator #(
		.TRIM_EACH_SIDE (TRIM_EACH_SIDE),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.SUM_BITS       (SUM_BITS)
	) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.warmup_count_we    (warmup_count_we),
		.warmup_count_wdata (warmup_count_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.sample             (sample),
		.last               (last),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.trimmed_sum        (trimmed_sum),
		.too_few            (too_few)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the block's run state, kept in step with every accepted item.
	logic [tsa_pkg::WARMUP_W-1:0] warmup_now = tsa_pkg::WARMUP_RESET;
	trio_t                        high_three;
	trio_t                        low_three;
	logic [SUM_BITS-1:0]          run_total;
	bit                           run_saturated;
	logic [tsa_pkg::COUNT_W-1:0]  run_pos;
	int unsigned                  kept_count;

	// Results owed by the block, oldest first.
	trim_result_t pending_totals[$];
	row_t         directed_rows[$];

	int  mismatches = 0;
	int  items_sent = 0;
	int  totals_checked = 0;
	int  short_results = 0;
	int  saturated_results = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	bit  tail_calm = 1'b0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < MAX_PRINTED)
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic clear_run();
		int i;
		for (i = 0; i < TRIM_EACH_SIDE; i++) begin
			high_three[i] = '0;
			low_three[i]  = '1;
		end
		run_total     = '0;
		run_saturated = 1'b0;
		run_pos       = '0;
		kept_count    = 0;
	endtask

	// Places x into a sorted list that holds 'used' valid entries. A new value goes in
	// front of the first entry it beats; equal values queue up behind, which leaves the
	// removed total unchanged whichever of the equal positions ends up trimmed.
	function automatic trio_t insert_sorted(input trio_t lst, input int unsigned used,
			input logic [SAMPLE_BITS-1:0] x, input bit want_big);
		int unsigned pos;
		int unsigned fill_to;
		int          i;
		bit          found;
		trio_t       res;
		res   = lst;
		pos   = 0;
		found = 1'b0;
		for (i = 0; i < TRIM_EACH_SIDE; i++) begin
			if (!found && i < used) begin
				if (want_big ? (x > lst[i]) : (x < lst[i]))
					found = 1'b1;
				else
					pos = i + 1;
			end
		end
		if (pos < TRIM_EACH_SIDE) begin
			fill_to = (used < TRIM_EACH_SIDE) ? used + 1 : TRIM_EACH_SIDE;
			for (i = int'(fill_to) - 1; i > int'(pos); i--)
				res[i] = res[i-1];
			res[pos] = x;
		end
		return res;
	endfunction

	// Advances the shadow state by one accepted item and, for a closing item, queues
	// the result the block owes.
	task automatic fold_sample(input logic [SAMPLE_BITS-1:0] x, input logic closing);
		logic [SUM_BITS:0] grown;
		logic [63:0]       removed;
		int unsigned       used;
		int                i;
		trim_result_t      owed;
		if (run_pos >= tsa_pkg::COUNT_W'(warmup_now)) begin
			used  = (kept_count < TRIM_EACH_SIDE) ? kept_count : TRIM_EACH_SIDE;
			grown = {1'b0, run_total} + (SUM_BITS+1)'(x);
			if (run_saturated || grown > {1'b0, SUM_ALL_ONES}) begin
				run_total     = SUM_ALL_ONES;
				run_saturated = 1'b1;
			end else begin
				run_total = grown[SUM_BITS-1:0];
			end
			high_three = insert_sorted(high_three, used, x, 1'b1);
			low_three  = insert_sorted(low_three, used, x, 1'b0);
			if (kept_count < KEEP_NEEDED)
				kept_count++;
		end
		if (run_pos != tsa_pkg::COUNT_MAX)
			run_pos++;
		if (closing) begin
			if (kept_count < KEEP_NEEDED) begin
				owed = '{total: '0, short_run: 1'b1};
				short_results++;
			end else if (run_saturated) begin
				owed = '{total: SUM_ALL_ONES, short_run: 1'b0};
				saturated_results++;
			end else begin
				removed = '0;
				for (i = 0; i < TRIM_EACH_SIDE; i++)
					removed = removed + 64'(high_three[i]) + 64'(low_three[i]);
				owed.total     = SUM_BITS'(64'(run_total) - removed);
				owed.short_run = 1'b0;
			end
			pending_totals.push_back(owed);
			clear_run();
		end
	endtask

	// Offers one item and holds it until the block takes it. A short gap may come
	// first. The item is folded into the shadow state at the edge that takes it.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] x, input logic closing,
			input bit may_pause);
		int gap;
		if (may_pause && !tail_calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= x;
		last     <= closing;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		fold_sample(x, closing);
		items_sent++;
	endtask

	// The warm-up register is only written with the block idle: the sender stops,
	// every owed result is collected, and the input register is given time to drain.
	task automatic set_warmup(input logic [tsa_pkg::WARMUP_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		warmup_count_we    <= 1'b1;
		warmup_count_wdata <= v;
		@(posedge clk);
		warmup_count_we <= 1'b0;
		warmup_now = v;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] draw_duration(input int style);
		case (style)
			0: return $urandom;
			// Narrow range, so runs are full of equal samples.
			1: return $urandom_range(0, 7);
			// Crowded at the top of the range.
			2: return 32'hFFFF_FFFF - $urandom_range(0, 7);
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic add_row(input row_kind_t kind, input logic [SAMPLE_BITS-1:0] value,
			input logic closes, input logic known_answer,
			input logic [SUM_BITS-1:0] want_total, input logic want_short);
		row_t r;
		r.kind         = kind;
		r.value        = value;
		r.closes       = closes;
		r.known_answer = known_answer;
		r.want_total   = want_total;
		r.want_short   = want_short;
		directed_rows.push_back(r);
	endtask

	// The receiver stalls in bursts of random length; the quiet spells between
	// bursts vary in length. In the tail of the run it never stalls.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!tail_calm && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every result the block hands over is matched against the oldest owed one.
	always @(posedge clk) begin
		trim_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_totals.size() == 0) begin
				report_mismatch("result with nothing owed", 64'(trimmed_sum), 64'd0);
			end else begin
				want = pending_totals.pop_front();
				if (trimmed_sum !== want.total)
					report_mismatch("trimmed_sum", 64'(trimmed_sum), 64'(want.total));
				if (too_few !== want.short_run)
					report_mismatch("too_few", 64'(too_few), 64'(want.short_run));
				totals_checked++;
			end
		end
	end

	// Ends the run if neither channel nor the register port moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || warmup_count_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item or result moved for %0d cycles", idle_cycles);
			$display("** trimmed_sum_accumulator: FAILED **");
			$finish;
		end
	end

	initial begin
		int   r;
		int   phase;
		int   n;
		int   run_left;
		int   run_style;
		bit   run_pauses;
		logic closing;
		logic [tsa_pkg::WARMUP_W-1:0] next_warm;
		row_t row;

		clear_run();

		// Directed table. Reset leaves the warm-up at two.
		// A run that closes on its very first item ends inside the warm-up.
		add_row(ROW_SAMPLE, 32'd5,          1'b1, 1'b1, '0, 1'b1);
		// Both extremes are dropped in the warm-up, then exactly six are kept,
		// both extremes among them, so all six are trimmed and nothing is left.
		add_row(ROW_SAMPLE, 32'hFFFF_FFFF,  1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd0,          1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd0,          1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'hFFFF_FFFF,  1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd1,          1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd2,          1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd3,          1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd4,          1'b1, 1'b1, '0, 1'b0);
		// A run of equal samples: seven kept after the warm-up.
		for (r = 0; r < 9; r++)
			add_row(ROW_SAMPLE, 32'd7, r == 8, 1'b0, '0, 1'b0);
		// No warm-up at all, and only five samples kept, one short of a trim.
		add_row(ROW_WARMUP, 32'd0,          1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd10,         1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd20,         1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd30,         1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd40,         1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_SAMPLE, 32'd50,         1'b1, 1'b1, '0, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WARMUP) begin
				set_warmup(row.value[tsa_pkg::WARMUP_W-1:0]);
			end else begin
				send_sample(row.value, row.closes, 1'b1);
				// Where the answer is obvious it replaces the predicted one, so the
				// block is held to the hand-written value on these rows.
				if (row.known_answer)
					pending_totals[pending_totals.size()-1] =
						'{total: row.want_total, short_run: row.want_short};
			end
		end

		// One long run of mostly all-ones samples, so the sum climbs high in its range.
		set_warmup(tsa_pkg::WARMUP_W'($urandom_range(0, 15)));
		for (n = 0; n < LONG_RUN_ITEMS; n++)
			send_sample(($urandom_range(0, 15) == 0) ? $urandom : 32'hFFFF_FFFF,
				n == LONG_RUN_ITEMS - 1, 1'b1);

		// Random part. Most runs are long enough to be trimmed; about a quarter are
		// short, some closing inside the warm-up. Runs carry across phase edges, so a
		// warm-up write regularly lands in the middle of a run.
		run_left   = 0;
		run_style  = 0;
		run_pauses = 1'b1;
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: next_warm = '1;
				1: next_warm = '0;
				RAND_PHASES - 1: next_warm = tsa_pkg::WARMUP_RESET;
				default: next_warm = tsa_pkg::WARMUP_W'($urandom_range(0, 15));
			endcase
			set_warmup(next_warm);
			tail_calm = (phase == RAND_PHASES - 1);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (run_left == 0) begin
					if ($urandom_range(0, 3) != 0)
						run_left = int'(warmup_now) + KEEP_NEEDED + $urandom_range(0, 20);
					else
						run_left = $urandom_range(1, int'(warmup_now) + KEEP_NEEDED - 1);
					run_style  = $urandom_range(0, 3);
					run_pauses = ($urandom_range(0, 3) != 0);
				end
				// The very last item of the stimulus closes whatever run is open.
				closing = (run_left == 1) || (tail_calm && n == PHASE_ITEMS - 1);
				send_sample(draw_duration(run_style), closing, run_pauses);
				run_left = closing ? 0 : run_left - 1;
			end
		end

		in_valid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d items in directed, long and random runs", items_sent);
		$display("%0d trimmed totals checked: %0d short runs, %0d saturated sums",
			totals_checked, short_results, saturated_results);
		if (mismatches == 0 && pending_totals.size() == 0)
			$display("** trimmed_sum_accumulator: PASSED **");
		else
			$display("** trimmed_sum_accumulator: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/tsa_pkg.sv
hdl/tsa_sorted_list.sv
hdl/tsa_trim_out.sv
hdl/trimmed_sum_accumulator.sv
tb/sv/tb_top.sv
